// ----- src/quadrature_counter_with_speed_macros.svh -----
// Assertion macros for the quadrature counter checker
`ifndef QUADRATURE_COUNTER_WITH_SPEED_MACROS_SVH
`define QUADRATURE_COUNTER_WITH_SPEED_MACROS_SVH

// same-cycle implication
`define QCS_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("qcs assertion failed");

// next-cycle implication
`define QCS_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("qcs assertion failed");

`endif

// ----- src/qcs_pkg.sv -----
`default_nettype none

package qcs_pkg;

    localparam int COUNT_WIDTH_DEF = 32;
    localparam int SPEED_W         = 48;
    localparam int WINDOW_W        = 34;
    localparam int CPR_W           = 16;
    localparam int TIME_W          = 64;
    localparam int POS_W           = 32;
    localparam int DATA_W          = 64;
    localparam int ADDR_W          = 4;

    // 60 * 256 = 15360 = 2^14 - 2^10
    localparam int SCALE_SHIFT     = 14;
    localparam int SCALE_SUB_SHIFT = 10;

    localparam logic [WINDOW_W-1:0] WINDOW_NS_RESET      = WINDOW_W'(64'd1000000000);
    localparam logic [CPR_W-1:0]    COUNTS_PER_REV_RESET = CPR_W'(1024);

    localparam logic [SPEED_W-1:0] SPEED_POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [SPEED_W-1:0] SPEED_NEG_MAG = 48'h8000_0000_0000;

    localparam int REG_WINDOW_NS      = 0;
    localparam int REG_COUNTS_PER_REV = 1;

    localparam logic [ADDR_W-1:0] ADDR_WINDOW_NS      = ADDR_W'(REG_WINDOW_NS * 8);
    localparam logic [ADDR_W-1:0] ADDR_COUNTS_PER_REV = ADDR_W'(REG_COUNTS_PER_REV * 8);

    typedef struct packed {
        logic [WINDOW_W-1:0] window_ns;
        logic [CPR_W-1:0]    counts_per_rev;
    } cfg_t;

    typedef struct packed {
        logic take;
        logic load_fast;
        logic step;
        logic load_slow;
    } cmd_t;

    typedef struct packed {
        logic close;
        logic div_done;
    } sts_t;

endpackage

`default_nettype wire

// ----- src/qcs_if.sv -----
`default_nettype none

interface qcs_sample_if;
    logic        valid;
    logic        ready;
    logic        pin_a;
    logic        pin_b;
    logic [63:0] time_now;

    modport source (output valid, pin_a, pin_b, time_now, input ready);
    modport sink   (input valid, pin_a, pin_b, time_now, output ready);
endinterface

interface qcs_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [47:0] speed_rpm_q8;
    logic               speed_valid;

    modport source (output valid, position, speed_rpm_q8, speed_valid, input ready);
    modport sink   (input valid, position, speed_rpm_q8, speed_valid, output ready);
endinterface

`default_nettype wire

// ----- src/qcs_regs.sv -----
`default_nettype none

module qcs_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qcs_pkg::ADDR_W-1:0] paddr,
    input  logic [qcs_pkg::DATA_W-1:0] pwdata,
    output logic [qcs_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output qcs_pkg::cfg_t              cfg
);
    import qcs_pkg::*;

    logic [WINDOW_W-1:0] window_reg;
    logic [CPR_W-1:0]    cpr_reg;
    logic                wr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_NS_RESET;
            cpr_reg    <= COUNTS_PER_REV_RESET;
        end
        else if (wr)
        begin
            if (paddr == ADDR_WINDOW_NS)
            begin
                window_reg <= pwdata[WINDOW_W-1:0];
            end
            if (paddr == ADDR_COUNTS_PER_REV)
            begin
                cpr_reg <= pwdata[CPR_W-1:0];
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == ADDR_WINDOW_NS)
        begin
            prdata = DATA_W'(window_reg);
        end
        else if (paddr == ADDR_COUNTS_PER_REV)
        begin
            prdata = DATA_W'(cpr_reg);
        end
    end

    assign cfg.window_ns      = window_reg;
    assign cfg.counts_per_rev = cpr_reg;

endmodule

`default_nettype wire

// ----- src/qcs_datapath.sv -----
`default_nettype none

module qcs_datapath #(
    parameter int COUNT_WIDTH = qcs_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  qcs_pkg::cmd_t                     cmd,
    output qcs_pkg::sts_t                     sts,
    input  qcs_pkg::cfg_t                     cfg,
    input  logic                              pin_a,
    input  logic                              pin_b,
    input  logic [qcs_pkg::TIME_W-1:0]        time_now,
    output logic signed [qcs_pkg::POS_W-1:0]  position,
    output logic signed [qcs_pkg::SPEED_W-1:0] speed_rpm_q8,
    output logic                              speed_valid
);
    import qcs_pkg::*;

    localparam int DW    = COUNT_WIDTH + SCALE_SHIFT;
    localparam int CNT_W = $clog2(DW);
    localparam int SW    = (DW > SPEED_W) ? DW : SPEED_W;

    logic                   last_a_reg;
    logic                   last_b_reg;
    logic                   started_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] wsc_reg;
    logic [TIME_W-1:0]      wst_reg;

    logic                   neg_reg;
    logic [DW-1:0]          quo_reg;
    logic [CPR_W-1:0]       rem_reg;
    logic [CNT_W-1:0]       div_cnt_reg;
    logic [POS_W-1:0]       pos_hold_reg;

    logic [POS_W-1:0]       pos_out_reg;
    logic [SPEED_W-1:0]     speed_out_reg;
    logic                   valid_out_reg;

    logic [TIME_W-1:0]      elapsed;
    logic                   close;
    logic                   rise_a;
    logic                   rise_b;
    logic [COUNT_WIDTH-1:0] count_a;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] diff;
    logic                   diff_neg;
    logic [COUNT_WIDTH-1:0] mag;
    logic [DW-1:0]          dividend;
    logic [CPR_W-1:0]       cpr_eff;
    logic [CPR_W:0]         rem_sh;
    logic                   ge;
    logic [CPR_W-1:0]       rem_new;
    logic [SPEED_W-1:0]     lim;
    logic [SPEED_W-1:0]     mag_sat;
    logic [SPEED_W-1:0]     speed_res;

    assign elapsed = time_now - wst_reg;
    assign close   = started_reg && (elapsed >= TIME_W'(cfg.window_ns));

    assign rise_a = pin_a && !last_a_reg;
    assign rise_b = pin_b && !last_b_reg;

    always_comb
    begin
        count_a = count_reg;
        if (rise_a)
        begin
            count_a = pin_b ? count_reg - COUNT_WIDTH'(1) : count_reg + COUNT_WIDTH'(1);
        end
        count_next = count_a;
        if (rise_b)
        begin
            count_next = pin_a ? count_a + COUNT_WIDTH'(1) : count_a - COUNT_WIDTH'(1);
        end
    end

    assign diff     = count_reg - wsc_reg;
    assign diff_neg = diff[COUNT_WIDTH-1];
    assign mag      = diff_neg ? (~diff + COUNT_WIDTH'(1)) : diff;
    assign dividend = (DW'(mag) << SCALE_SHIFT) - (DW'(mag) << SCALE_SUB_SHIFT);

    assign cpr_eff = (cfg.counts_per_rev == '0) ? CPR_W'(1) : cfg.counts_per_rev;
    assign rem_sh  = {rem_reg, quo_reg[DW-1]};
    assign ge      = rem_sh >= {1'b0, cpr_eff};
    assign rem_new = ge ? CPR_W'(rem_sh - {1'b0, cpr_eff}) : rem_sh[CPR_W-1:0];

    assign lim       = neg_reg ? SPEED_NEG_MAG : SPEED_POS_MAX;
    assign mag_sat   = (SW'(quo_reg) > SW'(lim)) ? lim : SPEED_W'(quo_reg);
    assign speed_res = neg_reg ? (~mag_sat + SPEED_W'(1)) : mag_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_a_reg  <= 1'b0;
            last_b_reg  <= 1'b0;
            started_reg <= 1'b0;
            count_reg   <= '0;
            wsc_reg     <= '0;
            wst_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.take)
        begin
            last_a_reg  <= pin_a;
            last_b_reg  <= pin_b;
            started_reg <= 1'b1;
            count_reg   <= count_next;
            if (!started_reg || close)
            begin
                wst_reg <= time_now;
                wsc_reg <= count_reg;
            end
            div_cnt_reg <= CNT_W'(DW - 1);
        end
        else if (cmd.step)
        begin
            div_cnt_reg <= div_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && close)
        begin
            neg_reg      <= diff_neg;
            quo_reg      <= dividend;
            rem_reg      <= '0;
            pos_hold_reg <= POS_W'(count_next);
        end
        else if (cmd.step)
        begin
            quo_reg <= {quo_reg[DW-2:0], ge};
            rem_reg <= rem_new;
        end

        if (cmd.load_fast)
        begin
            pos_out_reg   <= POS_W'(count_next);
            speed_out_reg <= '0;
            valid_out_reg <= 1'b0;
        end
        else if (cmd.load_slow)
        begin
            pos_out_reg   <= pos_hold_reg;
            speed_out_reg <= speed_res;
            valid_out_reg <= 1'b1;
        end
    end

    assign sts.close    = close;
    assign sts.div_done = (div_cnt_reg == '0);

    assign position     = signed'(pos_out_reg);
    assign speed_rpm_q8 = signed'(speed_out_reg);
    assign speed_valid  = valid_out_reg;

endmodule

`default_nettype wire

// ----- src/qcs_ctrl.sv -----
`default_nettype none

module qcs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          sample_valid,
    output logic          sample_ready,
    output logic          result_valid,
    input  logic          result_ready,
    output qcs_pkg::cmd_t cmd,
    input  qcs_pkg::sts_t sts
);
    import qcs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ov_reg;
    logic   ov_next;
    logic   out_free;

    assign out_free = !ov_reg || result_ready;

    always_comb
    begin
        state_next    = state_reg;
        sample_ready  = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                sample_ready  = out_free;
                cmd.take      = sample_valid && out_free;
                cmd.load_fast = cmd.take && !sts.close;
                if (cmd.take && sts.close)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    cmd.load_slow = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (cmd.load_fast || cmd.load_slow)
        begin
            ov_next = 1'b1;
        end
        else if (result_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign result_valid = ov_reg;

endmodule

`default_nettype wire

// ----- src/quadrature_counter_with_speed.sv -----
`default_nettype none

// Quadrature counter with windowed speed. Each sample word carries pins A and B and a
// nanosecond timestamp and yields one result word: the wrapped position, and when a
// measurement window closes on that sample, the speed in rpm*256 with speed_valid set.
// A sample that closes no window is taken and its result word loaded in the same cycle, so
// samples flow at one per cycle while result words are accepted. A sample that closes a window
// passes through its intake, a bit-serial restoring divider by counts_per_rev that forms
// COUNT_WIDTH+14 quotient bits, and a load, and no new sample is taken until after the load. A result
// word that waits unaccepted holds the intake, and the load, until it is taken. Registers:
// window_ns at byte address 0x0, counts_per_rev at 0x8, 64-bit data; a counts_per_rev of
// zero acts as one.
module quadrature_counter_with_speed #(
    parameter int COUNT_WIDTH = qcs_pkg::COUNT_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    qcs_sample_if.sink                 sample,
    qcs_result_if.source               result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [qcs_pkg::ADDR_W-1:0] paddr,
    input  logic [qcs_pkg::DATA_W-1:0] pwdata,
    output logic [qcs_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import qcs_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    qcs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qcs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .sample_ready (sample.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .cmd          (cmd),
        .sts          (sts)
    );

    qcs_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg          (cfg),
        .pin_a        (sample.pin_a),
        .pin_b        (sample.pin_b),
        .time_now     (sample.time_now),
        .position     (result.position),
        .speed_rpm_q8 (result.speed_rpm_q8),
        .speed_valid  (result.speed_valid)
    );

endmodule

`default_nettype wire

// ----- src/qcs_checker.sv -----
`default_nettype none

`include "quadrature_counter_with_speed_macros.svh"

module qcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        sample_ready,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] position,
    input logic [47:0] speed,
    input logic        speed_valid
);

    `QCS_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid)
    `QCS_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable(position) && $stable(speed) && $stable(speed_valid))
    `QCS_ASSERT_NOW(a_speed_zero, result_valid && !speed_valid, speed == '0)
    `QCS_ASSERT_NOW(a_intake_blocked, result_valid && !result_ready, !sample_ready)

endmodule

bind quadrature_counter_with_speed qcs_checker u_qcs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .position     (result.position),
    .speed        (result.speed_rpm_q8),
    .speed_valid  (result.speed_valid)
);

`default_nettype wire

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import qcs_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RESET_CYCLES   = 6;
    localparam int RPM_FACTOR     = 15360;
    localparam int IDLE_HEAVY_PCT = 52;
    localparam int IDLE_LIGHT_PCT = 7;
    localparam int HOLD_CYCLES    = 400;
    localparam int DIV_LATENCY    = 64;
    localparam int DRAIN_LIMIT    = 20000;
    localparam int PHASE_ITEMS    = 130;
    localparam longint TIMEOUT_NS = 64'd6_000_000;

    localparam logic [WINDOW_W-1:0] WINDOW_MAX = '1;
    localparam logic [CPR_W-1:0]    CPR_MAX    = '1;
    // levels {a, b} around one encoder cycle, forward direction
    localparam logic [7:0] QUAD_SEQ = 8'b01_11_10_00;

    typedef struct {
        logic signed [POS_W-1:0]   position;
        logic signed [SPEED_W-1:0] speed_rpm_q8;
        logic                      speed_valid;
    } reading_t;

    typedef enum int { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_t;

    class encoder_scoreboard;
        logic [WINDOW_W-1:0] window_ns;
        logic [CPR_W-1:0]    counts_per_rev;
        logic                prev_a;
        logic                prev_b;
        logic [POS_W-1:0]    count;
        logic [POS_W-1:0]    mark_count;
        logic [TIME_W-1:0]   mark_time;
        bit                  armed;
        reading_t            pending_q[$];
        int                  errors;

        function new();
            window_ns      = WINDOW_NS_RESET;
            counts_per_rev = COUNTS_PER_REV_RESET;
            prev_a         = 1'b0;
            prev_b         = 1'b0;
            count          = '0;
            mark_count     = '0;
            mark_time      = '0;
            armed          = 1'b0;
            errors         = 0;
        endfunction

        function void set_register(int idx, logic [DATA_W-1:0] value);
            if (idx == REG_WINDOW_NS)
                window_ns = value[WINDOW_W-1:0];
            else if (idx == REG_COUNTS_PER_REV)
                counts_per_rev = value[CPR_W-1:0];
        endfunction

        function logic [SPEED_W-1:0] rpm_of(logic [POS_W-1:0] delta);
            logic             neg;
            logic [POS_W-1:0] absval;
            logic [63:0]      mag;
            logic [63:0]      divisor;
            logic [63:0]      res;
            logic [63:0]      lim;
            neg     = delta[POS_W-1];
            absval  = neg ? (~delta + POS_W'(1)) : delta;
            mag     = 64'(absval);
            divisor = (counts_per_rev == '0) ? 64'd1 : 64'(counts_per_rev);
            res     = (mag * 64'(RPM_FACTOR)) / divisor;
            lim     = neg ? 64'(SPEED_NEG_MAG) : 64'(SPEED_POS_MAX);
            if (res > lim)
                res = lim;
            if (neg)
                res = ~res + 64'd1;
            return res[SPEED_W-1:0];
        endfunction

        function void note_sample(logic a, logic b, logic [TIME_W-1:0] t);
            reading_t r;
            r.speed_rpm_q8 = '0;
            r.speed_valid  = 1'b0;
            if (!armed)
            begin
                armed      = 1'b1;
                mark_time  = t;
                mark_count = count;
            end
            else if (t - mark_time >= 64'(window_ns))
            begin
                r.speed_rpm_q8 = rpm_of(count - mark_count);
                r.speed_valid  = 1'b1;
                mark_time      = t;
                mark_count     = count;
            end
            if (!prev_a && a)
                count = b ? count - POS_W'(1) : count + POS_W'(1);
            if (!prev_b && b)
                count = a ? count + POS_W'(1) : count - POS_W'(1);
            prev_a     = a;
            prev_b     = b;
            r.position = count;
            pending_q.push_back(r);
        endfunction

        function void check_result(logic signed [POS_W-1:0] pos,
                                   logic signed [SPEED_W-1:0] spd, logic sv);
            reading_t e;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result word: position %0d speed %0d valid %0b",
                         $time, pos, spd, sv);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (pos !== e.position)
            begin
                $display("%0t: position expected %0d actual %0d", $time, e.position, pos);
                errors++;
            end
            if (spd !== e.speed_rpm_q8)
            begin
                $display("%0t: speed_rpm_q8 expected %0d actual %0d",
                         $time, e.speed_rpm_q8, spd);
                errors++;
            end
            if (sv !== e.speed_valid)
            begin
                $display("%0t: speed_valid expected %0b actual %0b", $time, e.speed_valid, sv);
                errors++;
            end
        endfunction
    endclass

    logic              clk   = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              hold_req = 1'b0;

    idle_mode_t        idle_mode = IDLE_NONE;
    logic [TIME_W-1:0] now_ns;
    int                quad_phase;

    encoder_scoreboard board = new();

    qcs_sample_if sample ();
    qcs_result_if result ();

    quadrature_counter_with_speed uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #HALF_PERIOD clk = ~clk;

    task automatic send_sample(input logic a, input logic b, input logic [TIME_W-1:0] t);
        int gap;
        int pct;
        gap = 0;
        pct = (idle_mode == IDLE_SENDER) ? IDLE_HEAVY_PCT :
              (idle_mode == IDLE_BOTH)   ? IDLE_LIGHT_PCT : 0;
        while ($urandom_range(99) < pct)
            gap++;
        if (gap > 0)
        begin
            sample.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample.valid    <= 1'b1;
        sample.pin_a    <= a;
        sample.pin_b    <= b;
        sample.time_now <= t;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
    endtask

    task automatic drain(input int extra);
        int waited;
        waited = 0;
        sample.valid <= 1'b0;
        @(posedge clk);
        while (board.pending_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_register(input int idx, input logic [DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= (idx == REG_WINDOW_NS) ? ADDR_WINDOW_NS : ADDR_COUNTS_PER_REV;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(idx, value);
    endtask

    task automatic configure(input logic [WINDOW_W-1:0] w, input logic [CPR_W-1:0] c);
        write_register(REG_WINDOW_NS, 64'(w));
        write_register(REG_COUNTS_PER_REV, 64'(c));
    endtask

    task automatic run_motion(input int n, input logic [TIME_W-1:0] step_hi);
        int         dir;
        logic [1:0] ab;
        dir = ($urandom_range(1) != 0) ? 1 : -1;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 8)
                dir = -dir;
            if ($urandom_range(99) >= 10)
                quad_phase = (quad_phase + dir + 4) % 4;
            ab     = QUAD_SEQ[quad_phase*2 +: 2];
            now_ns = now_ns + ({$urandom, $urandom} % (step_hi + 64'd1));
            send_sample(ab[1], ab[0], now_ns);
        end
    endtask

    task automatic run_noise(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(1) != 0)
                now_ns = {$urandom, $urandom};
            else
                now_ns = now_ns + 64'($urandom_range(0, 3));
            send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), now_ns);
        end
    endtask

    task automatic random_phase(input idle_mode_t mode, input bit squeeze);
        logic [WINDOW_W-1:0] w;
        logic [CPR_W-1:0]    c;
        int                  left;
        int                  burst;
        case ($urandom_range(4))
            0:       w = 1;
            1:       w = WINDOW_W'($urandom_range(1, 400));
            2:       w = WINDOW_W'({$urandom, $urandom});
            3:       w = WINDOW_MAX - WINDOW_W'($urandom_range(0, 1000));
            default: w = WINDOW_NS_RESET;
        endcase
        case ($urandom_range(3))
            0:       c = 1;
            1:       c = CPR_MAX;
            2:       c = CPR_W'($urandom_range(1, 65535));
            default: c = COUNTS_PER_REV_RESET;
        endcase
        configure(w, c);
        idle_mode = mode;
        if (squeeze)
            hold_req <= 1'b1;
        left = PHASE_ITEMS;
        while (left > 0)
        begin
            burst = $urandom_range(4, 30);
            if (burst > left)
                burst = left;
            if ($urandom_range(99) < 80)
                run_motion(burst, 64'(w) >> $urandom_range(0, 4));
            else
                run_noise(burst);
            left -= burst;
        end
        drain(4);
        idle_mode = IDLE_NONE;
    endtask

    initial
    begin : result_side
        int hold_left;
        bit hold_taken;
        int pct;
        hold_left    = 0;
        hold_taken   = 1'b0;
        result.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sample.valid && sample.ready)
                board.note_sample(sample.pin_a, sample.pin_b, sample.time_now);
            if (result.valid && result.ready)
                board.check_result(result.position, result.speed_rpm_q8, result.speed_valid);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            pct = (idle_mode == IDLE_RECEIVER) ? IDLE_HEAVY_PCT :
                  (idle_mode == IDLE_BOTH)     ? IDLE_LIGHT_PCT : 0;
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= ($urandom_range(99) >= pct);
        end
    end

    initial
    begin : stimulus
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        sample.valid    = 1'b0;
        sample.pin_a    = 1'b0;
        sample.pin_b    = 1'b0;
        sample.time_now = '0;
        now_ns          = '0;
        quad_phase      = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first word only opens the window; both edges against low history
        send_sample(1'b1, 1'b1, 64'd0);
        send_sample(1'b0, 1'b0, 64'd5);
        send_sample(1'b1, 1'b0, 64'd10);
        send_sample(1'b1, 1'b1, 64'd20);
        send_sample(1'b0, 1'b1, 64'd999_999_999);
        send_sample(1'b0, 1'b0, 64'd1_000_000_000);
        send_sample(1'b0, 1'b1, 64'd1_000_000_100);
        send_sample(1'b1, 1'b1, 64'd1_000_000_200);
        send_sample(1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFF0);
        send_sample(1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
        // close just across the timestamp wrap
        send_sample(1'b1, 1'b1, 64'd999_999_983);
        send_sample(1'b1, 1'b0, 64'd999_999_984);
        drain(4);

        // zero window and zero counts per revolution
        configure('0, '0);
        send_sample(1'b0, 1'b1, 64'd2_000_000_000);
        send_sample(1'b1, 1'b1, 64'd2_000_000_000);
        send_sample(1'b1, 1'b0, 64'd2_000_000_000);
        send_sample(1'b0, 1'b0, 64'd2_000_000_001);
        drain(4);

        configure(WINDOW_MAX, CPR_MAX);
        now_ns = 64'd2_000_000_001 + 64'(WINDOW_MAX);
        send_sample(1'b1, 1'b0, now_ns);
        send_sample(1'b1, 1'b1, now_ns + 64'(WINDOW_MAX) - 64'd1);
        send_sample(1'b0, 1'b1, now_ns + 64'(WINDOW_MAX));
        now_ns = now_ns + 64'(WINDOW_MAX);
        drain(4);

        configure(1, 1);
        quad_phase = 3;
        run_motion(6, 64'd2);
        drain(4);

        random_phase(IDLE_NONE, 1'b0);
        random_phase(IDLE_SENDER, 1'b0);
        random_phase(IDLE_RECEIVER, 1'b0);
        random_phase(IDLE_BOTH, 1'b0);
        random_phase(IDLE_NONE, 1'b1);
        random_phase(IDLE_SENDER, 1'b0);
        random_phase(IDLE_RECEIVER, 1'b0);
        random_phase(IDLE_BOTH, 1'b0);

        drain(DIV_LATENCY);
        if (board.pending_q.size() != 0)
        begin
            $display("%0t: %0d result words never arrived", $time, board.pending_q.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("quadrature_counter_with_speed regression: pass");
        else
            $display("quadrature_counter_with_speed regression: fail");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("quadrature_counter_with_speed regression: fail");
        $finish;
    end

endmodule
